### rtl/gsgc_pkg.sv
package gsgc_pkg;

  localparam int GRID_COLS_DEF = 1024;
  localparam int GRID_ROWS_DEF = 256;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    CFG_HALF_COLS = 3'd0,
    CFG_HALF_ROWS = 3'd1,
    CFG_CELL_X    = 3'd2,
    CFG_CELL_Y    = 3'd3,
    CFG_RISE_X    = 3'd4,
    CFG_RISE_Y    = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_CLEAR    = 2'd0,
    MODE_BIN      = 2'd1,
    MODE_CLASSIFY = 2'd2,
    MODE_NONE     = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] x_mm;
    logic signed [31:0] y_mm;
    logic signed [15:0] z_mm;
    logic [15:0]        intensity;
  } in_item_t;

  typedef struct packed {
    logic               is_ground;
    logic signed [31:0] out_x_mm;
    logic signed [31:0] out_y_mm;
    logic signed [15:0] out_z_mm;
    logic [15:0]        out_intensity;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DIV,
    ST_LOCATE,
    ST_RD,
    ST_WAIT,
    ST_WRITE,
    ST_NEIGH,
    ST_MUL,
    ST_CMP,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture the accepted item
    logic clr_start;  // reset the clear sweep address
    logic clr_step;   // write zero and advance
    logic div_start;
    logic rd_center;  // read the point's cell
    logic wr_bin;     // write the updated cell
    logic rd_neigh;   // read the next neighbour
    logic mul;        // form the cross products
    logic cmp;        // fold the compare into the flag
    logic out_load;   // move the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic in_grid;
    logic interior;   // interior cell with a non-empty center
    logic bin_ok;     // center count below full
    logic neigh_last;
    logic out_busy;
  } sts_t;

endpackage

### rtl/gsgc_ram.sv
module gsgc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/gsgc_div.sv
// restoring floor division of a signed 32 bit value by an unsigned 16 bit divisor,
// one quotient bit per cycle
module gsgc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic [15:0]        den,
  output logic               done,
  output logic signed [32:0] quo
);

  logic [31:0] mag_r, mag_nxt;
  logic [31:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic        busy_r, busy_nxt;
  logic [15:0] den_r, den_nxt;
  logic [16:0] trial;

  always_comb begin
    mag_nxt  = mag_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    den_nxt  = den_r;
    trial    = {rem_r[15:0], mag_r[31]};
    if (start) begin
      neg_nxt  = num[31];
      mag_nxt  = num[31] ? 32'(-num) : 32'(num);
      den_nxt  = (den == 16'd0) ? 16'd1 : den;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r != 6'd0) begin
      mag_nxt = {mag_r[30:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    mag_r <= mag_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    den_r <= den_nxt;
  end

  assign done = busy_r && (cnt_r == 6'd0);
  // negative numerator rounds toward minus infinity
  assign quo = neg_r ? (-$signed({1'b0, q_r}) - ((rem_r != '0) ? 33'sd1 : 33'sd0))
                     : $signed({1'b0, q_r});

endmodule

### rtl/gsgc_ctrl.sv
module gsgc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  gsgc_pkg::sts_t     sts,
  output gsgc_pkg::cmd_t     cmd
);
  import gsgc_pkg::*;

  state_t state_r, state_nxt;
  logic [1:0] mode_r, mode_nxt;

  // the store is swept clear right after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      mode_r  <= MODE_NONE;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          mode_nxt = in_mode;
          case (mode_t'(in_mode))
            MODE_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_nxt = ST_CLEAR;
            end
            MODE_BIN, MODE_CLASSIFY: begin
              cmd.div_start = 1'b1;
              state_nxt = ST_DIV;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_DIV: if (sts.div_done) state_nxt = ST_LOCATE;
      ST_LOCATE: begin
        if (!sts.in_grid) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.rd_center = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_RD: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (mode_r == MODE_BIN) begin
          state_nxt = ST_WRITE;
        end else if (sts.interior) begin
          cmd.rd_neigh = 1'b1;
          state_nxt = ST_NEIGH;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_WRITE: begin
        cmd.wr_bin = sts.bin_ok;
        state_nxt = ST_IDLE;
      end
      ST_NEIGH: state_nxt = ST_MUL;
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp = 1'b1;
        if (sts.neigh_last) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.rd_neigh = 1'b1;
          state_nxt = ST_NEIGH;
        end
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### rtl/gsgc_dp.sv
module gsgc_dp #(
  parameter int GRID_COLS = gsgc_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = gsgc_pkg::GRID_ROWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gsgc_pkg::in_item_t                  in_data,
  input  logic                                cfg_we,
  input  logic [gsgc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gsgc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  gsgc_pkg::cmd_t                      cmd,
  output gsgc_pkg::sts_t                      sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output gsgc_pkg::out_item_t                 out_data
);
  import gsgc_pkg::*;

  localparam int CW = $clog2(GRID_COLS);
  localparam int RW = $clog2(GRID_ROWS);
  localparam int AW = CW + RW;
  // store addressed as {row, col}, padded to a power of two
  localparam int DEPTH = 1 << AW;
  localparam int HC_MAX = GRID_COLS / 2;
  localparam int HR_MAX = GRID_ROWS / 2;

  // configuration registers
  logic [9:0]  half_cols_r;
  logic [7:0]  half_rows_r;
  logic [15:0] cell_x_r, cell_y_r, rise_x_r, rise_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_cols_r <= 10'd334;
      half_rows_r <= 8'd100;
      cell_x_r    <= 16'd150;
      cell_y_r    <= 16'd150;
      rise_x_r    <= 16'd26;
      rise_y_r    <= 16'd26;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HALF_COLS: half_cols_r <= cfg_data[9:0];
        CFG_HALF_ROWS: half_rows_r <= cfg_data[7:0];
        CFG_CELL_X:    cell_x_r    <= cfg_data;
        CFG_CELL_Y:    cell_y_r    <= cfg_data;
        CFG_RISE_X:    rise_x_r    <= cfg_data;
        CFG_RISE_Y:    rise_y_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  in_item_t item_r;
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
  end

  // two dividers side by side for the column and row
  logic dx_done, dy_done;
  logic signed [32:0] qx, qy;
  gsgc_div u_divx (.clk, .rst_n, .start(cmd.div_start), .num(in_data.x_mm),
    .den(cell_x_r), .done(dx_done), .quo(qx));
  gsgc_div u_divy (.clk, .rst_n, .start(cmd.div_start), .num(in_data.y_mm),
    .den(cell_y_r), .done(dy_done), .quo(qy));

  logic signed [34:0] nx, ny, col_s, row_s, cols_s, rows_s;
  always_comb begin
    nx = (32'(half_cols_r) > HC_MAX) ? 35'(HC_MAX) : 35'(half_cols_r);
    ny = (32'(half_rows_r) > HR_MAX) ? 35'(HR_MAX) : 35'(half_rows_r);
    cols_s = nx <<< 1;
    rows_s = ny <<< 1;
    col_s = nx + 35'(qx);
    row_s = ny - 35'(qy);
  end

  logic in_grid;
  assign in_grid = (row_s >= 0) && (row_s < rows_s) && (col_s >= 0) && (col_s < cols_s);

  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic          edge_r;
  always_ff @(posedge clk) begin
    if (dx_done) begin
      col_r  <= col_s[CW-1:0];
      row_r  <= row_s[RW-1:0];
      edge_r <= (row_s == 0) || (row_s == rows_s - 1) || (col_s == 0) || (col_s == cols_s - 1);
    end
  end

  // grid store, read address chosen by the step
  logic [AW-1:0] clr_addr_r;
  logic [1:0]    nb_r;
  logic [AW-1:0] center, raddr, waddr;
  logic          we;
  logic [31:0]   sum_q, sum_w;
  logic [15:0]   cnt_q, cnt_w;

  assign center = {row_r, col_r};

  always_comb begin
    case (nb_r)
      2'd0: raddr = {row_r - RW'(1), col_r};
      2'd1: raddr = {row_r + RW'(1), col_r};
      2'd2: raddr = {row_r, col_r - CW'(1)};
      default: raddr = {row_r, col_r + CW'(1)};
    endcase
    if (cmd.rd_center) raddr = center;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      nb_r <= '0;
    end else begin
      if (cmd.clr_start) clr_addr_r <= '0;
      else if (cmd.clr_step) clr_addr_r <= clr_addr_r + AW'(1);
      if (cmd.rd_center) nb_r <= '0;
      else if (cmd.cmp && cmd.rd_neigh) nb_r <= nb_r + 2'd1;
    end
  end

  // the center cell data is on the read port the cycle after rd_center; capture it then
  logic cap_r;
  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= 1'b0;
    else cap_r <= cmd.rd_center;
  end

  logic signed [31:0] sc_r;
  logic [15:0]        nc_r;
  always_ff @(posedge clk) begin
    if (cap_r) begin
      sc_r <= sum_q;
      nc_r <= cnt_q;
    end
  end

  // center values for bin and classify come from the registers captured after the center read
  assign sts.bin_ok = (nc_r != 16'hFFFF);
  assign sum_w = cmd.clr_step ? '0 : sc_r + 32'(signed'(item_r.z_mm));
  assign cnt_w = cmd.clr_step ? '0 : nc_r + 16'd1;
  assign we    = cmd.clr_step | cmd.wr_bin;
  assign waddr = cmd.clr_step ? clr_addr_r : center;

  gsgc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_sum (.clk, .we, .waddr, .wdata(sum_w),
    .raddr, .rdata(sum_q));
  gsgc_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_cnt (.clk, .we, .waddr, .wdata(cnt_w),
    .raddr, .rdata(cnt_q));

  // cross products; neighbour data is valid in the mul step
  logic signed [48:0] p1_r, p2_r;
  logic [31:0]        nn_r;
  logic [15:0]        rise_r;
  logic [47:0]        lim;
  logic signed [49:0] diff;
  logic [49:0]        adiff;
  logic               n2z_r, steep_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p1_r   <= sc_r * $signed({1'b0, cnt_q});
      p2_r   <= $signed(sum_q) * $signed({1'b0, nc_r});
      nn_r   <= nc_r * cnt_q;
      rise_r <= nb_r[1] ? rise_x_r : rise_y_r;
      n2z_r  <= (cnt_q == 16'd0);
    end
  end

  always_comb begin
    diff  = 50'(p1_r) - 50'(p2_r);
    adiff = diff[49] ? 50'(-diff) : 50'(diff);
    lim   = nn_r * rise_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_center) steep_r <= 1'b0;
    else if (cmd.cmp && !n2z_r && (adiff > 50'(lim))) steep_r <= 1'b1;
  end

  assign sts.clr_done   = (clr_addr_r == AW'(DEPTH - 1));
  assign sts.div_done   = dx_done & dy_done;
  assign sts.in_grid    = in_grid;
  assign sts.interior   = !edge_r && (nc_r != 16'd0);
  assign sts.neigh_last = (nb_r == 2'd3);
  assign sts.out_busy   = out_valid && out_stall;

  // output register
  logic valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.is_ground     <= !(sts.interior && steep_r);
      out_data.out_x_mm      <= item_r.x_mm;
      out_data.out_y_mm      <= item_r.y_mm;
      out_data.out_z_mm      <= item_r.z_mm;
      out_data.out_intensity <= item_r.intensity;
    end
  end

  assign out_valid = valid_r;

endmodule

### rtl/grid_slope_ground_classifier_top.sv
// grid local-slope ground classifier: points in millimetres are binned into a
// grid store of height sums and counts (mode 1), the store is cleared (mode 0)
// and points are classified against their four neighbours (mode 2, one result
// unless the point lies outside the grid). one item is handled at a time: a bin
// or classify is through before the next item can be taken, a classify of an
// occupied interior cell reads the grid store once per neighbour after the cell
// divider, and a result held by a stalled output also holds the next item. a
// clear sweeps the whole store, one cell per cycle over
// 2**(clog2(GRID_COLS)+clog2(GRID_ROWS)) cells, 262144 with the default grid;
// the same sweep runs right after reset, so the input stalls until it is done
// before its first transfer. configuration must be written only while idle; the
// block itself does not enforce this.
module grid_slope_ground_classifier_top #(
  parameter int GRID_COLS = gsgc_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = gsgc_pkg::GRID_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  gsgc_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gsgc_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [gsgc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsgc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gsgc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: one item at a time
  gsgc_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_stall, .in_mode(in_data.mode),
    .sts, .cmd);

  // datapath: dividers, grid store, products and output register
  gsgc_dp #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_dp (
    .clk, .rst_n, .in_data, .cfg_we, .cfg_index, .cfg_data, .cmd, .sts,
    .out_valid, .out_stall, .out_data);

endmodule
